[rtl/core/u8v_pkg.sv]
`default_nettype none

package u8v_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned CountW = 2;

  // Lead byte classes and their payload masks
  localparam logic [ByteW-1:0] AsciiMax   = 8'h7F;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;
  localparam logic [ByteW-1:0] ContMask   = 8'hC0;
  localparam logic [ByteW-1:0] ContCode   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Bits  = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Bits  = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Bits  = 8'h07;
  localparam logic [ByteW-1:0] ContBits   = 8'h3F;

  // Sequence lengths, counted in continuation bytes
  localparam logic [CountW-1:0] SeqNone = 2'd0;
  localparam logic [CountW-1:0] SeqTwo  = 2'd1;
  localparam logic [CountW-1:0] SeqThree = 2'd2;
  localparam logic [CountW-1:0] SeqFour = 2'd3;

  // Smallest code point that each sequence length may carry
  localparam logic [CodeW-1:0] MinTwo   = 21'h00080;
  localparam logic [CodeW-1:0] MinThree = 21'h00800;
  localparam logic [CodeW-1:0] MinFour  = 21'h10000;

  typedef logic [ByteW-1:0] data_byte_t;

endpackage

`default_nettype wire

[rtl/core/u8v_chan_if.sv]
`default_nettype none

// Byte channel into the validator
interface u8v_in_if
  import u8v_pkg::*;
();
  logic       valid;
  logic       ready;
  data_byte_t data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Verdict channel out of the validator
interface u8v_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

`default_nettype wire

[rtl/core/utf8_stream_validator_unit.sv]
`default_nettype none

// UTF-8 stream validator. A string enters one byte per transfer on in_i, with
// last_byte set on its final byte; exactly one verdict leaves on out_o for each
// string, is_valid = 1 when every sequence is well formed, not overlong and not
// cut off by the end of the string (surrogates and code points up to 0x1FFFFF
// pass). Bytes that are not final produce no transfer on out_o. The block takes
// one byte per cycle when not stalled: a byte is registered on entry, the
// sequence state and the verdict are updated as it leaves the entry register,
// and the verdict waits in an output register. The input stalls only while a
// verdict is held in the output register and the byte in the entry register
// is itself a final byte. Empty strings are not presented.
module utf8_stream_validator_unit
  import u8v_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  u8v_in_if.sink        in_i,
  u8v_out_if.source     out_o
);

  // Entry register
  logic        s1_valid_q;
  data_byte_t  s1_byte_q;
  logic        s1_last_q;
  logic        s1_fire;
  logic        out_free;

  // Sequence state
  logic [CountW-1:0] pending_q, pending_d;
  logic [CountW-1:0] seq_len_q, seq_len_d;
  logic [CodeW-1:0]  accum_q, accum_d;
  logic              err_q, err_d;

  // Verdict register
  logic out_valid_q;
  logic out_data_q;
  logic verdict;

  logic [CodeW-1:0] accum_shift;
  logic [CodeW-1:0] min_code;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;

  // Capture an incoming byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  assign accum_shift = {accum_q[CodeW-7:0], s1_byte_q[5:0] & ContBits[5:0]};

  // Select the overlong bound of the open sequence
  always_comb begin
    unique case (seq_len_q)
      SeqTwo:   min_code = MinTwo;
      SeqThree: min_code = MinThree;
      default:  min_code = MinFour;
    endcase
  end

  // Advance the sequence state by one byte
  always_comb begin
    pending_d = pending_q;
    seq_len_d = seq_len_q;
    accum_d   = accum_q;
    err_d     = err_q;
    if (!err_q) begin
      if (pending_q == SeqNone) begin
        priority if (s1_byte_q <= AsciiMax) begin
          pending_d = SeqNone;
        end else if ((s1_byte_q & Lead2Mask) == Lead2Code) begin
          accum_d   = {{(CodeW-ByteW){1'b0}}, s1_byte_q & Lead2Bits};
          pending_d = SeqTwo;
          seq_len_d = SeqTwo;
        end else if ((s1_byte_q & Lead3Mask) == Lead3Code) begin
          accum_d   = {{(CodeW-ByteW){1'b0}}, s1_byte_q & Lead3Bits};
          pending_d = SeqThree;
          seq_len_d = SeqThree;
        end else if ((s1_byte_q & Lead4Mask) == Lead4Code) begin
          accum_d   = {{(CodeW-ByteW){1'b0}}, s1_byte_q & Lead4Bits};
          pending_d = SeqFour;
          seq_len_d = SeqFour;
        end else begin
          err_d = 1'b1;
        end
      end else if ((s1_byte_q & ContMask) != ContCode) begin
        err_d     = 1'b1;
        pending_d = SeqNone;
      end else begin
        accum_d   = accum_shift;
        pending_d = pending_q - 2'd1;
        if (pending_q == SeqTwo) begin
          if (accum_shift < min_code) begin
            err_d = 1'b1;
          end
          seq_len_d = SeqNone;
          accum_d   = '0;
        end
      end
    end
  end

  assign verdict = !err_d && (pending_d == SeqNone);

  // Hold the sequence state; clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= SeqNone;
      seq_len_q <= SeqNone;
      accum_q   <= '0;
      err_q     <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        pending_q <= SeqNone;
        seq_len_q <= SeqNone;
        accum_q   <= '0;
        err_q     <= 1'b0;
      end else begin
        pending_q <= pending_d;
        seq_len_q <= seq_len_d;
        accum_q   <= accum_d;
        err_q     <= err_d;
      end
    end
  end

  // Load the verdict on the final byte, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_data_q <= verdict;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.is_valid = out_data_q;

  // Checks
  a_pending_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= seq_len_q || pending_q == SeqNone)
    else $error("pending count exceeds sequence length");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> pending_q == SeqNone && !err_q && accum_q == '0)
    else $error("state not cleared after final byte");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !(s1_fire && s1_last_q) |=> err_q)
    else $error("error flag dropped inside a string");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !(s1_fire && s1_last_q))
    else $error("verdict overwritten while held");

endmodule

`default_nettype wire
